// ===== design/stl_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package stl_pkg;
  localparam int LENGTH_BITS_DEF = 16;
  localparam int LINE_BITS_DEF   = 24;
  localparam int LINE_W = 24;
  localparam int LEN_W  = 16;
  localparam int KIND_W = 6;
  localparam int ITEM_W = 1 + 8 + KIND_W + LINE_W + LEN_W + 1;

  localparam logic [KIND_W-1:0] K_END = 6'd0, K_LPAREN = 6'd1, K_RPAREN = 6'd2,
    K_LBRACE = 6'd3, K_RBRACE = 6'd4, K_COMMA = 6'd5, K_SEMI = 6'd6, K_DOT = 6'd7,
    K_PLUS = 6'd8, K_MINUS = 6'd9, K_MUL = 6'd10, K_DIV = 6'd11, K_MOD = 6'd12,
    K_ASSIGN = 6'd13, K_EQ = 6'd14, K_NOT = 6'd15, K_NEQ = 6'd16, K_LT = 6'd17,
    K_LE = 6'd18, K_GT = 6'd19, K_GE = 6'd20, K_AND = 6'd21, K_OR = 6'd22,
    K_IF = 6'd23, K_IDENT = 6'd31, K_NUMBER = 6'd32, K_STRING = 6'd33,
    K_UNKNOWN = 6'd34;

  typedef enum logic [3:0] {
    M_IDLE, M_SLASH, M_COMMENT, M_IDENT, M_NUMBER, M_STR, M_STR_ESC,
    M_OP_EQ, M_OP_NOT, M_OP_LT, M_OP_GT, M_AMP, M_PIPE, M_UNK, M_DONE
  } mode_t;

  typedef struct packed {
    logic                is_token;
    logic [7:0]          text_byte;
    logic [KIND_W-1:0]   token_kind;
    logic [LINE_W-1:0]   line_number;
    logic [LEN_W-1:0]    text_length;
    logic                last;
  } item_t;

  typedef struct packed {
    logic [1:0] n;
    item_t      r0;
    item_t      r1;
    item_t      r2;
  } burst_t;

  function automatic logic [31:0] kw_word(input logic [2:0] k);
    case (k)
      3'd0: kw_word = 32'h6966;
      3'd1: kw_word = 32'h656C6966;
      3'd2: kw_word = 32'h656C7365;
      3'd3: kw_word = 32'h666F72;
      3'd4: kw_word = 32'h6F626A;
      3'd5: kw_word = 32'h696E74;
      3'd6: kw_word = 32'h737472;
      default: kw_word = 32'h626F6F6C;
    endcase
  endfunction

  function automatic logic [2:0] kw_len(input logic [2:0] k);
    case (k)
      3'd0: kw_len = 3'd2;
      3'd1, 3'd2, 3'd7: kw_len = 3'd4;
      default: kw_len = 3'd3;
    endcase
  endfunction
endpackage
`default_nettype wire

// ===== design/stl_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module stl_front import stl_pkg::*; #(
  parameter int LENGTH_BITS = LENGTH_BITS_DEF,
  parameter int LINE_BITS   = LINE_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [23:0] cfg_wdata,
  input  wire logic        step,
  input  wire logic [7:0]  b,
  input  wire logic        eoi,
  output burst_t           burst
);
  localparam logic [LINE_BITS-1:0]   LINE_MAX = {LINE_BITS{1'b1}};
  localparam logic [LENGTH_BITS-1:0] LEN_MAX  = {LENGTH_BITS{1'b1}};

  mode_t                  mode_r, mode_nxt;
  logic [LINE_BITS-1:0]   line_r, line_nxt;
  logic [31:0]            pre_r, pre_nxt;
  logic [LENGTH_BITS-1:0] len_r, len_nxt;

  item_t res [3];
  logic [1:0] n;

  function automatic logic [LINE_BITS-1:0] sat_line(input logic [23:0] v);
    logic [55:0] w;
    w = {32'd0, v};
    sat_line = (w > {24'd0, 32'(LINE_MAX)}) ? LINE_MAX : w[LINE_BITS-1:0];
  endfunction

  function automatic logic [LEN_W-1:0] out_len(input logic [LENGTH_BITS-1:0] v);
    logic [63:0] w;
    w = {{(64-LENGTH_BITS){1'b0}}, v};
    out_len = w[LEN_W-1:0];
  endfunction

  logic [LINE_W-1:0] line_o;
  logic [63:0] line_w;
  assign line_w = {{(64-LINE_BITS){1'b0}}, line_r};
  assign line_o = line_w[LINE_W-1:0];

  logic is_alpha, is_digit;
  assign is_alpha = (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A) || b == 8'h5F;
  assign is_digit = b >= 8'h30 && b <= 8'h39;

  logic [KIND_W-1:0] wkind;
  always_comb begin
    wkind = K_IDENT;
    for (int k = 7; k >= 0; k--)
      if (len_r == LENGTH_BITS'(kw_len(3'(k))) && pre_r == kw_word(3'(k)))
        wkind = K_IF + KIND_W'(k);
  end

  always_comb begin
    item_t t;
    logic [7:0] ab;
    logic [LENGTH_BITS-1:0] nl;
    logic flushing;
    mode_nxt = mode_r;
    line_nxt = line_r;
    pre_nxt  = pre_r;
    len_nxt  = len_r;
    n = 2'd0;
    res[0] = '0; res[1] = '0; res[2] = '0;
    t = '0;
    ab = b;
    flushing = 1'b0;
    nl = (len_r < LEN_MAX) ? len_r + 1'b1 : len_r;

    if (mode_r != M_DONE) begin
      flushing = eoi;
      if (!eoi) begin
        unique case (mode_r)
          M_IDLE: ;
          M_COMMENT:
            if (b == 8'h0A) begin
              if (line_r < LINE_MAX) line_nxt = line_r + 1'b1;
              mode_nxt = M_IDLE;
            end
          M_STR: begin
            if (b == 8'h22) begin
              t = '0; t.is_token = 1'b1; t.token_kind = K_STRING;
              t.line_number = line_o; t.text_length = out_len(len_r);
              res[n] = t; n = n + 1'b1; mode_nxt = M_IDLE;
            end else if (b == 8'h5C) mode_nxt = M_STR_ESC;
            else begin
              t = '0; t.text_byte = b; res[n] = t; n = n + 1'b1;
              len_nxt = nl;
              if (nl <= LENGTH_BITS'(4)) pre_nxt = {pre_r[23:0], b};
            end
          end
          M_STR_ESC: begin
            ab = (b == 8'h6E) ? 8'h0A : (b == 8'h74) ? 8'h09 : b;
            t = '0; t.text_byte = ab; res[n] = t; n = n + 1'b1;
            len_nxt = nl;
            if (nl <= LENGTH_BITS'(4)) pre_nxt = {pre_r[23:0], ab};
            mode_nxt = M_STR;
          end
          default: begin
            if (mode_r == M_SLASH && b == 8'h2F) mode_nxt = M_COMMENT;
            else if ((mode_r == M_IDENT && (is_alpha || is_digit)) ||
                     (mode_r == M_NUMBER && is_digit)) begin
              t = '0; t.text_byte = b; res[n] = t; n = n + 1'b1;
              len_nxt = nl;
              if (nl <= LENGTH_BITS'(4)) pre_nxt = {pre_r[23:0], b};
            end else if (b == 8'h3D && (mode_r == M_OP_EQ || mode_r == M_OP_NOT ||
                                         mode_r == M_OP_LT || mode_r == M_OP_GT)) begin
              t = '0; t.is_token = 1'b1; t.line_number = line_o; t.text_length = LEN_W'(2);
              t.token_kind = (mode_r == M_OP_EQ) ? K_EQ : (mode_r == M_OP_NOT) ? K_NEQ :
                             (mode_r == M_OP_LT) ? K_LE : K_GE;
              res[n] = t; n = n + 1'b1; mode_nxt = M_IDLE;
            end else if ((mode_r == M_AMP && b == 8'h26) || (mode_r == M_PIPE && b == 8'h7C)) begin
              t = '0; t.is_token = 1'b1; t.line_number = line_o; t.text_length = LEN_W'(2);
              t.token_kind = (mode_r == M_AMP) ? K_AND : K_OR;
              res[n] = t; n = n + 1'b1; mode_nxt = M_IDLE;
            end else flushing = 1'b1;
          end
        endcase
      end

      if (flushing) begin
        t = '0; t.is_token = 1'b1; t.line_number = line_o; t.text_length = LEN_W'(1);
        case (mode_r)
          M_SLASH:  begin t.token_kind = K_DIV; res[n] = t; n = n + 1'b1; end
          M_OP_EQ:  begin t.token_kind = K_ASSIGN; res[n] = t; n = n + 1'b1; end
          M_OP_NOT: begin t.token_kind = K_NOT; res[n] = t; n = n + 1'b1; end
          M_OP_LT:  begin t.token_kind = K_LT; res[n] = t; n = n + 1'b1; end
          M_OP_GT:  begin t.token_kind = K_GT; res[n] = t; n = n + 1'b1; end
          M_UNK:    begin t.token_kind = K_UNKNOWN; res[n] = t; n = n + 1'b1; end
          M_IDENT: begin
            t.token_kind = wkind; t.text_length = out_len(len_r); res[n] = t; n = n + 1'b1;
          end
          M_NUMBER: begin
            t.token_kind = K_NUMBER; t.text_length = out_len(len_r); res[n] = t; n = n + 1'b1;
          end
          M_STR, M_STR_ESC: begin
            t.token_kind = K_UNKNOWN; t.text_length = out_len(len_r); res[n] = t; n = n + 1'b1;
          end
          M_AMP, M_PIPE: begin
            res[n] = '0;
            res[n].text_byte = (mode_r == M_AMP) ? 8'h26 : 8'h7C;
            n = n + 1'b1;
            t.token_kind = K_UNKNOWN; res[n] = t; n = n + 1'b1;
          end
          default: ;
        endcase
        mode_nxt = M_IDLE;
        if (eoi) begin
          t = '0; t.is_token = 1'b1; t.token_kind = K_END; t.line_number = line_o;
          res[n] = t; n = n + 1'b1;
          mode_nxt = M_DONE;
        end
      end

      if (!eoi && (mode_r == M_IDLE || flushing)) begin
        t = '0; t.is_token = 1'b1; t.line_number = line_o; t.text_length = LEN_W'(1);
        case (b)
          8'h20, 8'h09, 8'h0D: ;
          8'h0A: if (line_r < LINE_MAX) line_nxt = line_r + 1'b1;
          8'h28: begin t.token_kind = K_LPAREN; res[n] = t; n = n + 1'b1; end
          8'h29: begin t.token_kind = K_RPAREN; res[n] = t; n = n + 1'b1; end
          8'h7B: begin t.token_kind = K_LBRACE; res[n] = t; n = n + 1'b1; end
          8'h7D: begin t.token_kind = K_RBRACE; res[n] = t; n = n + 1'b1; end
          8'h2C: begin t.token_kind = K_COMMA; res[n] = t; n = n + 1'b1; end
          8'h3B: begin t.token_kind = K_SEMI; res[n] = t; n = n + 1'b1; end
          8'h2E: begin t.token_kind = K_DOT; res[n] = t; n = n + 1'b1; end
          8'h2B: begin t.token_kind = K_PLUS; res[n] = t; n = n + 1'b1; end
          8'h2D: begin t.token_kind = K_MINUS; res[n] = t; n = n + 1'b1; end
          8'h2A: begin t.token_kind = K_MUL; res[n] = t; n = n + 1'b1; end
          8'h25: begin t.token_kind = K_MOD; res[n] = t; n = n + 1'b1; end
          8'h2F: mode_nxt = M_SLASH;
          8'h3D: mode_nxt = M_OP_EQ;
          8'h21: mode_nxt = M_OP_NOT;
          8'h3C: mode_nxt = M_OP_LT;
          8'h3E: mode_nxt = M_OP_GT;
          8'h26: mode_nxt = M_AMP;
          8'h7C: mode_nxt = M_PIPE;
          8'h22: begin mode_nxt = M_STR; len_nxt = '0; pre_nxt = '0; end
          default: begin
            mode_nxt = is_alpha ? M_IDENT : is_digit ? M_NUMBER : M_UNK;
            len_nxt = LENGTH_BITS'(1);
            pre_nxt = {24'd0, b};
            res[n] = '0; res[n].text_byte = b; n = n + 1'b1;
          end
        endcase
      end
    end
    if (n != 2'd0) res[n - 1'b1].last = 1'b1;
  end

  assign burst = '{n: n, r0: res[0], r1: res[1], r2: res[2]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE;
      line_r <= sat_line(24'd1);
      pre_r  <= '0;
      len_r  <= '0;
    end else if (cfg_we) begin
      line_r <= sat_line(cfg_wdata);
    end else if (step) begin
      mode_r <= mode_nxt;
      line_r <= line_nxt;
      pre_r  <= pre_nxt;
      len_r  <= len_nxt;
    end
  end
endmodule
`default_nettype wire

// ===== design/stl_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
module stl_queue import stl_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   wr,
  input  wire burst_t din,
  output logic        room,
  output logic        valid,
  output item_t       dout,
  input  wire logic   rd
);
  localparam int DEPTH = 8;
  item_t mem [DEPTH];
  logic [2:0] wp_r, rp_r;
  logic [3:0] cnt_r;
  logic [3:0] add;

  assign add   = wr ? {2'b00, din.n} : 4'd0;
  assign room  = cnt_r <= 4'd5;
  assign valid = cnt_r != 4'd0;
  assign dout  = mem[rp_r];

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wp_r] <= din.r0;
      mem[wp_r + 3'd1] <= din.r1;
      mem[wp_r + 3'd2] <= din.r2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      wp_r  <= wp_r + add[2:0];
      rp_r  <= rp_r + {2'b00, rd};
      cnt_r <= cnt_r + add - {3'b000, rd};
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 4'd8)
    else $error("queue overflow");
  assert property (@(posedge clk) disable iff (!rst_n) rd |-> valid)
    else $error("read from empty queue");
  assert property (@(posedge clk) disable iff (!rst_n) wr |-> room)
    else $error("write without room");
endmodule
`default_nettype wire

// ===== design/script_token_lexer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Results are queued at the transfer that causes them and leave on out_ in order.
// Throughput: one source byte per cycle while the queue holds at most five entries;
// each byte yields up to three results, buffered by an eight-entry queue.
// Reset: synchronous active-low rst_n clears the lexer state and loads line 1.
module script_token_lexer import stl_pkg::*; #(
  parameter int LENGTH_BITS = LENGTH_BITS_DEF,
  parameter int LINE_BITS   = LINE_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [23:0] cfg_wdata,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // in_byte
  input  wire logic        in_tlast,   // end_of_input
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [55:0]      out_tdata,  // text_byte, token_kind, line_number, text_length, pad
  output logic             out_tuser,  // is_token
  output logic             out_tlast   // last
);
  burst_t burst;
  item_t  head;
  logic   room, step;

  assign in_tready = room;
  assign step = in_tvalid && room;

  stl_front #(.LENGTH_BITS(LENGTH_BITS), .LINE_BITS(LINE_BITS)) u_front (
    .clk, .rst_n, .cfg_we, .cfg_wdata, .step,
    .b(in_tdata), .eoi(in_tlast || in_tdata == 8'd0), .burst
  );

  stl_queue u_queue (
    .clk, .rst_n, .wr(step), .din(burst), .room, .valid(out_tvalid), .dout(head),
    .rd(out_tvalid && out_tready)
  );

  assign out_tdata = {2'b00, head.text_length, head.line_number, head.token_kind,
                      head.text_byte};
  assign out_tuser = head.is_token;
  assign out_tlast = head.last;
endmodule
`default_nettype wire

// ===== tb/sv/script_token_lexer_tb.sv =====
`timescale 1ns / 1ps
module script_token_lexer_tb;
  import stl_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam logic [7:0] LF = 8'h0A, TAB = 8'h09, CR = 8'h0D, SP = 8'h20;
  localparam logic [23:0] LINE_TOP = 24'hFFFFFF;
  localparam logic [15:0] LEN_TOP = 16'hFFFF;
  localparam logic [31:0] KW_CODE [8] = '{32'h6966, 32'h656C6966, 32'h656C7365, 32'h666F72,
                                          32'h6F626A, 32'h696E74, 32'h737472, 32'h626F6F6C};
  localparam int KW_SIZE [8] = '{2, 4, 4, 3, 3, 3, 3, 4};

  typedef struct {
    logic [7:0] b;
    logic       eoi;
  } src_t;

  logic        clk = 0;
  logic        rst_n;
  logic        cfg_we;
  logic [23:0] cfg_wdata;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [55:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;

  script_token_lexer dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  always #5 clk = ~clk;

  src_t  byte_q[$];
  item_t token_q[$];
  item_t step_items[$];

  mode_t       lx_mode;
  logic [23:0] line_cnt;
  logic [31:0] prefix;
  logic [15:0] tlen;

  int errors = 0;
  int n_bytes = 0;
  int n_results = 0;
  int n_tokens = 0;
  int cycles = 0;
  bit took = 0;
  int burst_left = 0;
  int gap_left = 0;
  bit hold_req = 0;
  int hold_left = 0;
  logic [31:0] stall_pat;
  int pat_age = 0;

  function automatic bit is_alpha(logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_";
  endfunction

  function automatic bit is_digit(logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  task automatic put_text(logic [7:0] b);
    item_t r;
    r = '0;
    r.text_byte = b;
    step_items.insert(step_items.size(), r);
  endtask

  task automatic put_tok(logic [KIND_W-1:0] k, logic [15:0] len);
    item_t r;
    r = '0;
    r.is_token = 1'b1;
    r.token_kind = k;
    r.line_number = line_cnt;
    r.text_length = len;
    step_items.insert(step_items.size(), r);
  endtask

  task automatic add_text(logic [7:0] b);
    put_text(b);
    if (tlen != LEN_TOP) tlen++;
    if (tlen <= 4) prefix = {prefix[23:0], b};
  endtask

  task automatic bump_line();
    if (line_cnt != LINE_TOP) line_cnt++;
  endtask

  task automatic start_text(mode_t m);
    lx_mode = m;
    tlen = '0;
    prefix = '0;
  endtask

  function automatic logic [KIND_W-1:0] word_kind();
    for (int k = 0; k < 8; k++)
      if (tlen == KW_SIZE[k] && prefix == KW_CODE[k]) return K_IF + KIND_W'(k);
    return K_IDENT;
  endfunction

  task automatic flush_pending();
    case (lx_mode)
      M_SLASH: put_tok(K_DIV, 1);
      M_IDENT: put_tok(word_kind(), tlen);
      M_NUMBER: put_tok(K_NUMBER, tlen);
      M_STR, M_STR_ESC: put_tok(K_UNKNOWN, tlen);
      M_OP_EQ: put_tok(K_ASSIGN, 1);
      M_OP_NOT: put_tok(K_NOT, 1);
      M_OP_LT: put_tok(K_LT, 1);
      M_OP_GT: put_tok(K_GT, 1);
      M_AMP: begin
        put_text("&");
        put_tok(K_UNKNOWN, 1);
      end
      M_PIPE: begin
        put_text("|");
        put_tok(K_UNKNOWN, 1);
      end
      M_UNK: put_tok(K_UNKNOWN, 1);
      default: ;
    endcase
    lx_mode = M_IDLE;
  endtask

  task automatic idle_byte(logic [7:0] b);
    case (b)
      SP, TAB, CR: ;
      LF: bump_line();
      "(": put_tok(K_LPAREN, 1);
      ")": put_tok(K_RPAREN, 1);
      "{": put_tok(K_LBRACE, 1);
      "}": put_tok(K_RBRACE, 1);
      ",": put_tok(K_COMMA, 1);
      ";": put_tok(K_SEMI, 1);
      ".": put_tok(K_DOT, 1);
      "+": put_tok(K_PLUS, 1);
      "-": put_tok(K_MINUS, 1);
      "*": put_tok(K_MUL, 1);
      "%": put_tok(K_MOD, 1);
      "/": lx_mode = M_SLASH;
      "=": lx_mode = M_OP_EQ;
      "!": lx_mode = M_OP_NOT;
      "<": lx_mode = M_OP_LT;
      ">": lx_mode = M_OP_GT;
      "&": lx_mode = M_AMP;
      "|": lx_mode = M_PIPE;
      "\"": start_text(M_STR);
      default: begin
        if (is_alpha(b)) start_text(M_IDENT);
        else if (is_digit(b)) start_text(M_NUMBER);
        else start_text(M_UNK);
        add_text(b);
      end
    endcase
  endtask

  task automatic lex_step(logic [7:0] b, logic eoi);
    step_items.delete();
    if (lx_mode == M_DONE) return;
    if (eoi || b == 8'h00) begin
      flush_pending();
      put_tok(K_END, 0);
      lx_mode = M_DONE;
    end else begin
      case (lx_mode)
        M_IDLE: idle_byte(b);
        M_COMMENT: if (b == LF) begin
          bump_line();
          lx_mode = M_IDLE;
        end
        M_STR: begin
          if (b == "\"") begin
            put_tok(K_STRING, tlen);
            lx_mode = M_IDLE;
          end else if (b == "\\") lx_mode = M_STR_ESC;
          else add_text(b);
        end
        M_STR_ESC: begin
          add_text(b == "n" ? LF : b == "t" ? TAB : b);
          lx_mode = M_STR;
        end
        default: begin
          if (lx_mode == M_SLASH && b == "/") lx_mode = M_COMMENT;
          else if ((lx_mode == M_IDENT && (is_alpha(b) || is_digit(b))) ||
                   (lx_mode == M_NUMBER && is_digit(b))) add_text(b);
          else if (b == "=" && lx_mode >= M_OP_EQ && lx_mode <= M_OP_GT) begin
            case (lx_mode)
              M_OP_EQ: put_tok(K_EQ, 2);
              M_OP_NOT: put_tok(K_NEQ, 2);
              M_OP_LT: put_tok(K_LE, 2);
              default: put_tok(K_GE, 2);
            endcase
            lx_mode = M_IDLE;
          end else if (lx_mode == M_AMP && b == "&") begin
            put_tok(K_AND, 2);
            lx_mode = M_IDLE;
          end else if (lx_mode == M_PIPE && b == "|") begin
            put_tok(K_OR, 2);
            lx_mode = M_IDLE;
          end else begin
            flush_pending();
            idle_byte(b);
          end
        end
      endcase
    end
    if (step_items.size() > 0) step_items[step_items.size()-1].last = 1'b1;
    foreach (step_items[i]) token_q.insert(token_q.size(), step_items[i]);
  endtask

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch at %0t on %s: got %0h, want %0h", $realtime, what, got, want);
    errors++;
  endtask

  // check results first, then predict from the input transfer
  always @(posedge clk) begin
    item_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        n_results++;
        if (token_q.size() == 0) begin
          report_mismatch("unexpected result", out_tdata, 0);
        end else begin
          want = token_q.pop_front();
          if (want.is_token) n_tokens++;
          if (out_tuser !== want.is_token) report_mismatch("is_token", out_tuser, want.is_token);
          if (out_tdata[7:0] !== want.text_byte)
            report_mismatch("text_byte", out_tdata[7:0], want.text_byte);
          if (out_tdata[13:8] !== want.token_kind)
            report_mismatch("token_kind", out_tdata[13:8], want.token_kind);
          if (out_tdata[37:14] !== want.line_number)
            report_mismatch("line_number", out_tdata[37:14], want.line_number);
          if (out_tdata[53:38] !== want.text_length)
            report_mismatch("text_length", out_tdata[53:38], want.text_length);
          if (out_tlast !== want.last) report_mismatch("last", out_tlast, want.last);
        end
      end
      if (in_tvalid && in_tready) begin
        lex_step(in_tdata, in_tlast);
        n_bytes++;
        took = 1;
      end
    end
  end

  always @(negedge clk) begin
    logic nv;
    if (took) begin
      void'(byte_q.pop_front());
      took = 0;
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
      end
    end
    nv = 0;
    if (!rst_n) nv = 0;
    else if (gap_left > 0) gap_left--;
    else if (byte_q.size() > 0) nv = 1;
    in_tvalid <= nv;
    if (nv) begin
      in_tdata <= byte_q[0].b;
      in_tlast <= byte_q[0].eoi;
    end
  end

  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = 400;
      hold_req = 0;
    end
    if (!rst_n) out_tready <= 1'b0;
    else if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      if (pat_age == 0) begin
        stall_pat = $urandom;
        if ($urandom_range(0, 3) == 0) stall_pat = '1;
        pat_age = 64;
      end
      pat_age--;
      out_tready <= stall_pat[pat_age % 32];
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic push_byte(logic [7:0] b, logic eoi = 1'b0);
    src_t s;
    s.b = b;
    s.eoi = eoi;
    byte_q.insert(byte_q.size(), s);
  endtask

  task automatic push_text(string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endtask

  task automatic push_token();
    string ops [24] = '{"(", ")", "{", "}", ",", ";", ".", "+", "-", "*", "%", "/", "=", "==",
                        "!", "!=", "<", "<=", ">", ">=", "&&", "||", "&", "|"};
    string words [10] = '{"if", "elif", "else", "for", "obj", "int", "str", "bool", "true",
                          "false"};
    string odd = "@#$?~`^[]:'\\";
    string esc = "nt\"\\q/";
    string alnum = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
    int n;
    case ($urandom_range(0, 9))
      0: push_text(words[$urandom_range(0, 9)]);
      1: begin
        n = $urandom_range(1, 8);
        push_byte(alnum[$urandom_range(0, 52)]);
        for (int i = 1; i < n; i++) push_byte(alnum[$urandom_range(0, 62)]);
      end
      2: begin
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++) push_byte(8'($urandom_range("0", "9")));
      end
      3: begin
        push_byte("\"");
        n = $urandom_range(0, 6);
        for (int i = 0; i < n; i++)
          case ($urandom_range(0, 5))
            0: begin
              push_byte("\\");
              push_byte(esc[$urandom_range(0, 5)]);
            end
            1: push_byte(LF);
            default: push_byte(8'($urandom_range(8'h20, 8'h7E)) == "\"" ? "a"
                               : 8'($urandom_range(8'h20, 8'h7E)));
          endcase
        if ($urandom_range(0, 15) != 0) push_byte("\"");
      end
      4, 5: push_text(ops[$urandom_range(0, 23)]);
      6: begin
        push_text("//");
        n = $urandom_range(0, 5);
        for (int i = 0; i < n; i++) push_byte(8'($urandom_range(1, 255)) == LF ? "x" : "y");
        push_byte(LF);
      end
      7: push_byte(LF);
      8: push_byte($urandom_range(0, 1) ? odd[$urandom_range(0, odd.len()-1)]
                                        : 8'($urandom_range(128, 255)));
      default: push_byte(8'($urandom_range(1, 255)));
    endcase
    case ($urandom_range(0, 3))
      0: push_byte(SP);
      1: push_byte($urandom_range(0, 1) ? TAB : CR);
      default: ;
    endcase
  endtask

  task automatic push_random(int count);
    int goal;
    goal = byte_q.size() + count;
    while (byte_q.size() < goal) push_token();
  endtask

  task automatic drain();
    while (byte_q.size() != 0 || took || token_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_first_line(logic [23:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    line_cnt = v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tlast = 1'b0;
    out_tready = 1'b0;
    lx_mode = M_IDLE;
    line_cnt = 24'd1;
    prefix = '0;
    tlen = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    push_text("if elif else for obj int str bool true x_9 1234 \"a\\n\\tb\\q");
    push_byte(LF);
    push_text("\" // skip\n(){},;.+-*%/a==b=c!=!d<=<e>=>f&&&g|||h");
    push_byte(8'hFF);
    push_byte(8'h80);
    push_text("@ ");
    drain();

    write_first_line(24'd0);
    hold_req = 1;
    push_random(150);
    drain();

    write_first_line(24'hFFFFFD);
    for (int i = 0; i < 6; i++) push_byte(LF);
    push_random(100);
    drain();

    write_first_line(24'($urandom));
    push_random(100);
    push_text("abc \"open");
    push_byte(8'($urandom_range(1, 255)), 1'b1);
    push_byte(8'h00);
    push_byte(8'h41, 1'b1);
    push_byte(8'h7F);
    drain();

    $display("covered %0d source bytes and %0d results (%0d tokens), first_line set to",
             n_bytes, n_results, n_tokens);
    $display("  1, 0, near its maximum and a random value, input closed by the end flag");
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
